// File: sv/obme_pkg.sv
// Shared types and constants for the order book match engine.
`default_nettype none
package obme_pkg;
  localparam int MaxOrders = 32;
  localparam int CW = $clog2(MaxOrders + 1);

  localparam logic [1:0] SIDE_ASK = 2'd0;
  localparam logic [1:0] SIDE_BID = 2'd1;

  localparam logic [2:0] REG_PRODUCT_SELECT = 3'd0;
  localparam logic [2:0] REG_PRODUCT_FILTER = 3'd1;
  localparam logic [2:0] REG_TIME_SELECT    = 3'd2;
  localparam logic [2:0] REG_TIME_FILTER    = 3'd3;

  typedef struct packed {
    logic [31:0] price;
    logic [31:0] amount;
    logic        sim;
  } entry_t;

  typedef enum logic [1:0] {
    OP_IDLE,
    OP_INSERT,
    OP_ROTATE,
    OP_HEAD
  } book_op_t;

  typedef struct packed {
    book_op_t op;
    entry_t   din;
  } book_ctl_t;
endpackage
`default_nettype wire

// File: sv/obme_cell.sv
// One book cell: holds an entry, takes part in sorted insert and rotation.
`default_nettype none
module obme_cell (
  input  wire logic               clk,
  input  wire obme_pkg::book_ctl_t ctl,
  input  wire logic               descending,
  input  wire logic               first,
  input  wire logic               occupied,
  input  wire logic               at_count,
  input  wire logic               is_last,
  input  wire logic               move_prev,
  input  wire obme_pkg::entry_t   prev,
  input  wire obme_pkg::entry_t   next,
  output logic                    move,
  output obme_pkg::entry_t        q
);
  obme_pkg::entry_t q_next;

  // an occupied entry moves up when the new one goes ahead of it
  always_comb begin
    move = occupied && (descending ? (q.price < ctl.din.price)
                                   : (q.price > ctl.din.price));
  end

  always_comb begin
    q_next = q;
    case (ctl.op)
      obme_pkg::OP_INSERT: begin
        if (move_prev) q_next = prev;
        else if (move || at_count) q_next = ctl.din;
      end
      obme_pkg::OP_ROTATE: begin
        if (is_last) q_next = ctl.din;
        else if (occupied) q_next = next;
      end
      obme_pkg::OP_HEAD: begin
        if (first) q_next = ctl.din;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end
endmodule
`default_nettype wire

// File: sv/obme_book.sv
// Row of cells forming one sorted order book.
`default_nettype none
module obme_book (
  input  wire logic                      clk,
  input  wire obme_pkg::book_ctl_t       ctl,
  input  wire logic                      descending,
  input  wire logic [obme_pkg::CW-1:0]   count,
  output obme_pkg::entry_t               head
);
  localparam int N = obme_pkg::MaxOrders;

  obme_pkg::entry_t q [N];
  logic             mv [N];

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      obme_pkg::entry_t prev_e;
      obme_pkg::entry_t next_e;
      logic             prev_mv;
      if (i == 0) begin : g_lo
        assign prev_e  = q[0];
        assign prev_mv = 1'b0;
      end else begin : g_mid
        assign prev_e  = q[i-1];
        assign prev_mv = mv[i-1];
      end
      if (i == N - 1) begin : g_hi
        assign next_e = q[i];
      end else begin : g_nx
        assign next_e = q[i+1];
      end
      obme_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .descending(descending),
        .first     (i == 0),
        .occupied  (obme_pkg::CW'(i) < count),
        .at_count  (obme_pkg::CW'(i) == count),
        .is_last   (obme_pkg::CW'(i + 1) == count),
        .move_prev (prev_mv),
        .prev      (prev_e),
        .next      (next_e),
        .move      (mv[i]),
        .q         (q[i])
      );
    end
  endgenerate

  assign head = q[0];
endmodule
`default_nettype wire

// File: sv/order_book_match_engine.sv
// Order book match engine: loads sorted books, then matches asks against bids.
// Load: one order per cycle, in_ready high while loading; an insert is registered in the cells.
// Match: after the last order, one bid visit per cycle unless a held sale waits on a busy output;
//   the bid cell row rotates each bid to the head, then the engine leaves the search and closes.
// Results leave through a one-beat output register; the final beat carries any held sale.
// Synchronous reset empties both books and clears the configuration registers.
`default_nettype none
module order_book_match_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  side,
  input  wire logic [15:0] product_id,
  input  wire logic [31:0] time_id,
  input  wire logic [31:0] price,
  input  wire logic [31:0] amount,
  input  wire logic        from_sim_user,
  input  wire logic        last_order,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             sale_valid,
  output logic [31:0]      sale_price,
  output logic [31:0]      sale_amount,
  output logic             sale_kind,
  output logic             sale_sim_user,
  output logic             final_result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int CW = obme_pkg::CW;

  typedef enum logic [1:0] {ST_LOAD, ST_MATCH, ST_FLUSH} state_t;

  typedef struct packed {
    logic [31:0] price;
    logic [31:0] amount;
    logic        kind;
    logic        sim;
  } sale_t;

  state_t state;
  logic [15:0] product_select;
  logic        product_filter_on;
  logic [31:0] time_select;
  logic        time_filter_on;
  logic [CW-1:0] ask_count, bid_count, ask_idx, bid_step;
  logic srch;
  logic pend_valid;
  sale_t pend;

  obme_pkg::book_ctl_t ask_ctl, bid_ctl;
  obme_pkg::entry_t ask_head, bid_head, new_e;

  logic in_acc, pass, out_free, eff, sale_now, last_bid;
  logic [31:0] qty;
  sale_t sale_new;

  obme_book u_ask (.clk(clk), .ctl(ask_ctl), .descending(1'b0),
                   .count(ask_count), .head(ask_head));
  obme_book u_bid (.clk(clk), .ctl(bid_ctl), .descending(1'b1),
                   .count(bid_count), .head(bid_head));

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign pass = (!product_filter_on || product_id == product_select) &&
                (!time_filter_on || time_id == time_select);
  assign new_e = '{price: price, amount: amount, sim: from_sim_user};

  assign eff      = srch && (ask_head.amount != 32'd0) && (bid_head.amount != 32'd0);
  assign sale_now = eff && (bid_head.price >= ask_head.price);
  assign qty      = (bid_head.amount < ask_head.amount) ? bid_head.amount : ask_head.amount;
  assign last_bid = (bid_step == bid_count - CW'(1));
  assign sale_new = '{price: ask_head.price, amount: qty,
                      kind: ask_head.sim ? 1'b0 : bid_head.sim,
                      sim: ask_head.sim | bid_head.sim};

  logic match_go;
  assign match_go = (state == ST_MATCH) && (ask_idx != ask_count) &&
                    (bid_count != '0) && (!pend_valid || out_free);

  // load the output register: release a held sale, or close the run
  logic out_load;
  assign out_load = (match_go && sale_now && pend_valid) || (state == ST_FLUSH && out_free);

  always_comb begin
    ask_ctl = '{op: obme_pkg::OP_IDLE, din: new_e};
    bid_ctl = '{op: obme_pkg::OP_IDLE, din: new_e};
    if (in_acc && pass) begin
      if (side == obme_pkg::SIDE_ASK && ask_count != CW'(obme_pkg::MaxOrders))
        ask_ctl.op = obme_pkg::OP_INSERT;
      if (side == obme_pkg::SIDE_BID && bid_count != CW'(obme_pkg::MaxOrders))
        bid_ctl.op = obme_pkg::OP_INSERT;
    end
    if (match_go) begin
      bid_ctl.op  = obme_pkg::OP_ROTATE;
      bid_ctl.din = bid_head;
      ask_ctl.din = ask_head;
      if (sale_now) begin
        bid_ctl.din.amount = bid_head.amount - qty;
        ask_ctl.din.amount = ask_head.amount - qty;
        ask_ctl.op = obme_pkg::OP_HEAD;
      end
      // advance to the next ask once every bid has passed the head
      if (last_bid) begin
        ask_ctl.op  = obme_pkg::OP_ROTATE;
        ask_ctl.din = ask_head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      product_select <= '0;
      product_filter_on <= 1'b0;
      time_select <= '0;
      time_filter_on <= 1'b0;
      ask_count <= '0;
      bid_count <= '0;
      ask_idx <= '0;
      bid_step <= '0;
      srch <= 1'b1;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          obme_pkg::REG_PRODUCT_SELECT: product_select <= cfg_data[15:0];
          obme_pkg::REG_PRODUCT_FILTER: product_filter_on <= cfg_data[0];
          obme_pkg::REG_TIME_SELECT:    time_select <= cfg_data;
          obme_pkg::REG_TIME_FILTER:    time_filter_on <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_LOAD: begin
          if (ask_ctl.op == obme_pkg::OP_INSERT) ask_count <= ask_count + CW'(1);
          if (bid_ctl.op == obme_pkg::OP_INSERT) bid_count <= bid_count + CW'(1);
          ask_idx  <= '0;
          bid_step <= '0;
          srch     <= 1'b1;
          if (in_acc && last_order) state <= ST_MATCH;
        end
        ST_MATCH: begin
          if (ask_idx == ask_count || bid_count == '0) begin
            state <= ST_FLUSH;
          end else if (match_go) begin
            if (sale_now) begin
              // hold the newest sale; release the older one
              pend <= sale_new;
              pend_valid <= 1'b1;
              if (pend_valid) begin
                sale_valid    <= 1'b1;
                sale_price    <= pend.price;
                sale_amount   <= pend.amount;
                sale_kind     <= pend.kind;
                sale_sim_user <= pend.sim;
                final_result  <= 1'b0;
              end
            end
            if (last_bid) begin
              bid_step <= '0;
              ask_idx  <= ask_idx + CW'(1);
              srch     <= 1'b1;
            end else begin
              bid_step <= bid_step + CW'(1);
              if (eff && !sale_now) srch <= 1'b0;
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            sale_valid    <= pend_valid;
            sale_price    <= pend_valid ? pend.price : 32'd0;
            sale_amount   <= pend_valid ? pend.amount : 32'd0;
            sale_kind     <= pend_valid ? pend.kind : 1'b0;
            sale_sim_user <= pend_valid ? pend.sim : 1'b0;
            final_result  <= 1'b1;
            pend_valid    <= 1'b0;
            ask_count     <= '0;
            bid_count     <= '0;
            state         <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  a_ask_bound: assert property (@(posedge clk) disable iff (rst)
    ask_count <= CW'(obme_pkg::MaxOrders) && bid_count <= CW'(obme_pkg::MaxOrders))
    else $error("book count beyond capacity");
  a_no_pend_load: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> !pend_valid)
    else $error("held sale left over while loading");
  a_flush_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH && out_free |=> out_valid && final_result && state == ST_LOAD)
    else $error("run did not close with a final beat");
  a_match_idx: assert property (@(posedge clk) disable iff (rst)
    state == ST_MATCH |-> ask_idx <= ask_count)
    else $error("ask index ran past the book");
endmodule
`default_nettype wire
